FILE: sv/bim_pkg.sv
package bim_pkg;

  localparam int unsigned TimeW = 64;

  typedef enum logic [1:0] {
    KIND_KERNEL     = 2'd0,
    KIND_CONCURRENT = 2'd1,
    KIND_OTHER      = 2'd2,
    KIND_SPARE      = 2'd3
  } kind_t;

  typedef struct packed {
    logic             is_interval;
    logic             last;
    logic [TimeW-1:0] rel_start;
    logic [TimeW-1:0] rel_end;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_READ,
    ST_SORT_CMP,
    ST_MERGE_READ,
    ST_MERGE_STEP,
    ST_EMIT_LAST
  } back_state_t;

endpackage

FILE: sv/bim_front.sv
module bim_front
  import bim_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TimeW-1:0] cfg_wdata,
  input  logic [1:0]       kind,
  input  logic [TimeW-1:0] start_time,
  input  logic [TimeW-1:0] end_time,
  input  logic             last_of_batch,
  output entry_t           entry
);

  logic [TimeW-1:0] base_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= '0;
    end else if (cfg_we) begin
      base_time <= cfg_wdata;
    end
  end

  always_comb begin
    entry.is_interval = (kind == KIND_KERNEL) || (kind == KIND_CONCURRENT);
    entry.last        = last_of_batch;
    entry.rel_start   = start_time - base_time;
    entry.rel_end     = end_time - base_time;
  end

endmodule

FILE: sv/bim_queue.sv
module bim_queue
  import bim_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   not_empty,
  output logic   full,
  output entry_t head
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t          mem [Depth];
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   wr_ptr;
  logic [AW:0]     count;

  assign not_empty = (count != '0);
  assign full      = (count == (AW+1)'(Depth));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: sv/bim_back.sv
module bim_back
  import bim_pkg::*;
#(
  parameter int unsigned MaxIntervals = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             avail,
  input  entry_t           head,
  output logic             pop,
  output logic             strobe,
  output logic [TimeW-1:0] busy_start,
  output logic [TimeW-1:0] busy_end,
  output logic [TimeW-1:0] busy_length,
  output logic             last_of_run,
  output logic             empty_batch,
  output logic             overflowed
);

  localparam int unsigned AW = $clog2(MaxIntervals);
  localparam int unsigned CW = AW + 1;

  // one memory holds start and end; insertion sort walks it one entry a step
  logic [2*TimeW-1:0] store [MaxIntervals];
  logic [2*TimeW-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [2*TimeW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  back_state_t      state, state_next;
  logic [CW-1:0]    count;
  logic             ovf;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [TimeW-1:0] key_s, key_e;
  logic [TimeW-1:0] cur_s, cur_e;

  logic [TimeW-1:0] rd_s, rd_e;
  assign rd_s = rd_data[2*TimeW-1:TimeW];
  assign rd_e = rd_data[TimeW-1:0];

  logic [2*TimeW-1:0] key_word;
  logic [TimeW-1:0]   key_cur_s, key_cur_e;

  always_ff @(posedge clk) begin
    key_word <= store[i[AW-1:0]];
  end

  // first compare of an outer step takes the key straight from the store
  assign key_cur_s = (j == i) ? key_word[2*TimeW-1:TimeW] : key_s;
  assign key_cur_e = (j == i) ? key_word[TimeW-1:0] : key_e;

  always_ff @(posedge clk) begin
    if (state == ST_SORT_CMP && j == i) begin
      key_s <= key_cur_s;
      key_e <= key_cur_e;
    end
  end

  logic after;
  assign after = (rd_s > key_cur_s) || ((rd_s == key_cur_s) && (rd_e > key_cur_e));

  logic [CW-1:0] n_eff;
  logic          load_fire;
  logic          store_ok;
  assign load_fire = (state == ST_LOAD) && avail;
  assign store_ok  = head.is_interval && (count < CW'(MaxIntervals));
  assign n_eff     = count + CW'(store_ok);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (load_fire && head.last) begin
          if (n_eff == '0) state_next = ST_EMIT_LAST;
          else if (n_eff == CW'(1)) state_next = ST_MERGE_READ;
          else state_next = ST_SORT_READ;
        end
      end
      ST_SORT_READ: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!(j != '0 && after) && (i + 1'b1 == count)) state_next = ST_MERGE_READ;
        else if (!(j != '0 && after)) state_next = ST_SORT_READ;
      end
      ST_MERGE_READ: state_next = ST_MERGE_STEP;
      ST_MERGE_STEP: begin
        if (i + 1'b1 == count) state_next = ST_EMIT_LAST;
        else state_next = ST_MERGE_READ;
      end
      ST_EMIT_LAST: state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    pop     = load_fire;
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {head.rel_start, head.rel_end};
    rd_addr = '0;
    unique case (state)
      ST_LOAD: begin
        wr_en   = load_fire && store_ok;
        rd_addr = '0;
      end
      ST_SORT_READ: rd_addr = AW'(j - 1'b1);
      ST_SORT_CMP: begin
        wr_en = 1'b1;
        if (j != '0 && after) begin
          wr_addr = j[AW-1:0];
          wr_data = rd_data;
        end else begin
          wr_addr = j[AW-1:0];
          wr_data = {key_cur_s, key_cur_e};
        end
        rd_addr = AW'(j - 2'd2);
      end
      ST_MERGE_READ: rd_addr = i[AW-1:0];
      default: rd_addr = i[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      count  <= '0;
      ovf    <= 1'b0;
      i      <= '0;
      j      <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (load_fire) begin
            if (head.last) begin
              count <= n_eff;
              ovf   <= ovf | (head.is_interval && !store_ok);
              i     <= (n_eff == CW'(1)) ? '0 : CW'(1);
              j     <= CW'(1);
              if (n_eff == '0) begin
                cur_s <= '0;
                cur_e <= '0;
              end
            end else begin
              if (store_ok) count <= count + 1'b1;
              if (head.is_interval && !store_ok) ovf <= 1'b1;
            end
          end
        end
        ST_SORT_READ: ;
        ST_SORT_CMP: begin
          if (j != '0 && after) begin
            j <= j - 1'b1;
          end else begin
            j <= i + 1'b1;
            i <= (i + 1'b1 == count) ? '0 : i + 1'b1;
          end
        end
        ST_MERGE_READ: ;
        ST_MERGE_STEP: begin
          i <= i + 1'b1;
          if (i == '0) begin
            cur_s <= rd_s;
            cur_e <= rd_e;
          end else if (rd_s > cur_e) begin
            strobe      <= 1'b1;
            busy_start  <= cur_s;
            busy_end    <= cur_e;
            busy_length <= cur_e - cur_s;
            last_of_run <= 1'b0;
            empty_batch <= 1'b0;
            overflowed  <= ovf;
            cur_s <= rd_s;
            cur_e <= rd_e;
          end else if (rd_e > cur_e) begin
            cur_e <= rd_e;
          end
        end
        ST_EMIT_LAST: begin
          strobe      <= 1'b1;
          busy_start  <= cur_s;
          busy_end    <= cur_e;
          busy_length <= cur_e - cur_s;
          last_of_run <= 1'b1;
          empty_batch <= (count == '0);
          overflowed  <= ovf;
          count <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/busy_interval_merger.sv
// flow: the last record of a batch passes through the queue to the back end, then
// the stored intervals are sorted by insertion sort and merged in one pass,
// one result per new busy period, the final result once merging ends
// throughput: one record per cycle while loading; busy from the last record to its final result
// reset: synchronous active-high rst clears base_time, counts, flags and control
// results carry a one-cycle strobe; the receiver cannot stall
module busy_interval_merger
  import bim_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TimeW-1:0] cfg_wdata,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind,
  input  logic [TimeW-1:0] start_time,
  input  logic [TimeW-1:0] end_time,
  input  logic             last_of_batch,
  output logic             strobe,
  output logic [TimeW-1:0] busy_start,
  output logic [TimeW-1:0] busy_end,
  output logic [TimeW-1:0] busy_length,
  output logic             last_of_run,
  output logic             empty_batch,
  output logic             overflowed
);

  entry_t entry, head;
  logic   take, q_full, q_avail, pop;
  logic   batch_pending;

  assign take = start && !busy;

  // one batch end in flight at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pending <= 1'b0;
    end else if (take && last_of_batch) begin
      batch_pending <= 1'b1;
    end else if (strobe && last_of_run) begin
      batch_pending <= 1'b0;
    end
  end

  assign busy = q_full || batch_pending;

  bim_front u_front (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .kind, .start_time, .end_time, .last_of_batch, .entry
  );

  bim_queue #(.Depth(2)) u_queue (
    .clk, .rst, .push(take), .push_data(entry), .pop,
    .not_empty(q_avail), .full(q_full), .head
  );

  bim_back #(.MaxIntervals(MAX_INTERVALS)) u_back (
    .clk, .rst, .avail(q_avail), .head, .pop,
    .strobe, .busy_start, .busy_end, .busy_length,
    .last_of_run, .empty_batch, .overflowed
  );

endmodule
